### rtl/assert_macros.svh
// Assertion helpers for the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nbs_pkg.sv
package nbs_pkg;

  // Fixed field widths of the stream words.
  localparam int unsigned IN_COORD_W   = 12;
  localparam int unsigned OUT_INDEX_W  = 6;
  localparam int unsigned IN_DATA_W    = 48;
  localparam int unsigned OUT_DATA_W   = 56;
  localparam int unsigned OUT_USER_W   = 2;

  // Bit positions inside out_tuser.
  localparam int unsigned USER_EMPTY   = 0;
  localparam int unsigned USER_OVF     = 1;

  // At most this many results leave the block per set.
  localparam int unsigned RESULT_LIMIT = 64;
  localparam int unsigned RES_W        = 7;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_LAT_I,
    S_CMP,
    S_EMIT_RD,
    S_EMIT_CHK,
    S_EMPTY
  } nbs_state_t;

  // Status of the containment compare unit.
  typedef struct packed {
    logic enclosed;
    logic hit;
  } nbs_cmp_t;

endpackage

### rtl/nbs_contain.sv
module nbs_contain #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [4*COORD_BITS-1:0] inner,
  input  logic [4*COORD_BITS-1:0] outer,
  input  logic                    same_idx,
  output nbs_pkg::nbs_cmp_t       res
);

  logic [COORD_BITS-1:0] ix, iy, iw, ih, ox, oy, ow, oh;
  logic [COORD_BITS:0]   i_right, i_bottom, o_right, o_bottom;

  assign ix = inner[0*COORD_BITS +: COORD_BITS];
  assign iy = inner[1*COORD_BITS +: COORD_BITS];
  assign iw = inner[2*COORD_BITS +: COORD_BITS];
  assign ih = inner[3*COORD_BITS +: COORD_BITS];
  assign ox = outer[0*COORD_BITS +: COORD_BITS];
  assign oy = outer[1*COORD_BITS +: COORD_BITS];
  assign ow = outer[2*COORD_BITS +: COORD_BITS];
  assign oh = outer[3*COORD_BITS +: COORD_BITS];

  // Edges carry one extra bit so that the sums never wrap.
  assign i_right  = {1'b0, ix} + {1'b0, iw};
  assign i_bottom = {1'b0, iy} + {1'b0, ih};
  assign o_right  = {1'b0, ox} + {1'b0, ow};
  assign o_bottom = {1'b0, oy} + {1'b0, oh};

  assign res.enclosed = (ix >= ox) && (iy >= oy) && (i_right <= o_right) &&
                        (i_bottom <= o_bottom);
  assign res.hit      = res.enclosed && !same_idx;

endmodule

### rtl/nested_box_suppression_unit.sv
// Nested box suppression. Boxes arrive on the in_ stream, one per word, with
// tdata holding x, y, width and height and tlast marking the final box of a
// set. Once the set is complete, every box that lies wholly inside another
// box of the set is removed; duplicates remove each other. Survivors leave on
// the out_ stream in load order with their load index, the final one with
// tlast. If nothing survives, a single all-zero word with the empty flag and
// tlast goes out. Boxes past MAX_BOXES are dropped and every word of that set
// carries the overflow flag.
// Loading accepts one box per cycle. Filtering runs each stored box
// against the others through one shared compare unit fed by a single read
// port of the box memory: box i is read and latched as the candidate, then
// compared with the stored boxes in index order until its first container
// is found or all have been tried. Emission then scans the store in load
// order, one word per survivor.
// in_tready is high only while loading. A stalled receiver holds the output
// register and the scan waits at the next survivor; the final word of a set
// may still wait while the next set begins loading. The synchronous active-low
// reset empties the set and the output register; the memories need no clearing.
module nested_box_suppression_unit #(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: box_x, box_y, box_width, box_height (lowest bits first)
  input  logic [nbs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: out_x, out_y, out_width, out_height, out_index, 2 zero bits
  output logic [nbs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser: empty_set, overflow
  output logic [nbs_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
  localparam int unsigned BOX_W = 4 * COORD_BITS;
  localparam int unsigned CW    = nbs_pkg::IN_COORD_W;
  localparam int unsigned RW    = nbs_pkg::RES_W;

  nbs_pkg::nbs_state_t state_r, state_nxt;

  logic [CNT_W-1:0] box_count_r, box_count_nxt;
  logic             dropped_r, dropped_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] jd_r, jd_nxt;
  logic [RW-1:0]    kept_r, kept_nxt;
  logic [RW-1:0]    emitted_r, emitted_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [BOX_W-1:0]               cand_r, cand_nxt;
  logic [nbs_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [nbs_pkg::OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic                           out_last_r, out_last_nxt;

  // Box store and the per-box containment marks, both with registered reads.
  logic [BOX_W-1:0] box_mem [MAX_BOXES];
  logic             mark_mem [MAX_BOXES];
  logic [BOX_W-1:0] rd_data_r;
  logic             mark_rd_r;
  logic [IDX_W-1:0] rd_addr;
  logic             box_we;
  logic             mark_we;
  logic [BOX_W-1:0] box_wd;

  logic             in_acc;
  logic             out_free;
  logic             last_i;
  logic             last_j;
  logic             cmp_done;
  logic [RW-1:0]    kept_plus;
  logic [RW-1:0]    kept_fin;
  logic             emit_last;
  nbs_pkg::nbs_cmp_t cmp;

  nbs_contain #(
    .COORD_BITS (COORD_BITS)
  ) u_contain (
    .inner    (cand_r),
    .outer    (rd_data_r),
    .same_idx (jd_r == i_r),
    .res      (cmp)
  );

  assign in_tready = (state_r == nbs_pkg::S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign last_i    = (CNT_W'(i_r) + CNT_W'(1)) == box_count_r;
  assign last_j    = (CNT_W'(jd_r) + CNT_W'(1)) == box_count_r;
  assign cmp_done  = cmp.hit || last_j;
  assign kept_plus = (kept_r == RW'(nbs_pkg::RESULT_LIMIT)) ? kept_r : kept_r + RW'(1);
  assign kept_fin  = cmp.hit ? kept_r : kept_plus;
  assign emit_last = (emitted_r + RW'(1)) == kept_r;

  // Incoming coordinates are sized to the stored coordinate width.
  assign box_wd = {COORD_BITS'(in_tdata[3*CW +: CW]), COORD_BITS'(in_tdata[2*CW +: CW]),
                   COORD_BITS'(in_tdata[1*CW +: CW]), COORD_BITS'(in_tdata[0*CW +: CW])};
  assign box_we  = in_acc && (box_count_r < CNT_W'(MAX_BOXES));
  assign mark_we = (state_r == nbs_pkg::S_CMP) && cmp_done;

  always_comb begin
    case (state_r)
      nbs_pkg::S_LAT_I: rd_addr = '0;
      nbs_pkg::S_CMP:   rd_addr = jd_r + IDX_W'(1);
      default:          rd_addr = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (box_we) begin
      box_mem[box_count_r[IDX_W-1:0]] <= box_wd;
    end
    if (mark_we) begin
      mark_mem[i_r] <= cmp.hit;
    end
    rd_data_r <= box_mem[rd_addr];
    mark_rd_r <= mark_mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nbs_pkg::S_LOAD: begin
        if (in_acc && in_tlast) state_nxt = nbs_pkg::S_RD_I;
      end
      nbs_pkg::S_RD_I:  state_nxt = nbs_pkg::S_LAT_I;
      nbs_pkg::S_LAT_I: state_nxt = nbs_pkg::S_CMP;
      nbs_pkg::S_CMP: begin
        if (cmp_done) begin
          if (!last_i) state_nxt = nbs_pkg::S_RD_I;
          else if (kept_fin == '0) state_nxt = nbs_pkg::S_EMPTY;
          else state_nxt = nbs_pkg::S_EMIT_RD;
        end
      end
      nbs_pkg::S_EMIT_RD: state_nxt = nbs_pkg::S_EMIT_CHK;
      nbs_pkg::S_EMIT_CHK: begin
        if (mark_rd_r) begin
          state_nxt = last_i ? nbs_pkg::S_LOAD : nbs_pkg::S_EMIT_RD;
        end else if (out_free) begin
          state_nxt = (emit_last || last_i) ? nbs_pkg::S_LOAD : nbs_pkg::S_EMIT_RD;
        end
      end
      nbs_pkg::S_EMPTY: begin
        if (out_free) state_nxt = nbs_pkg::S_LOAD;
      end
      default: state_nxt = nbs_pkg::S_LOAD;
    endcase
  end

  // Counters and output register.
  always_comb begin
    box_count_nxt = box_count_r;
    dropped_nxt   = dropped_r;
    i_nxt         = i_r;
    jd_nxt        = jd_r;
    kept_nxt      = kept_r;
    emitted_nxt   = emitted_r;
    cand_nxt      = cand_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      nbs_pkg::S_LOAD: begin
        if (in_acc) begin
          if (box_we) box_count_nxt = box_count_r + CNT_W'(1);
          else dropped_nxt = 1'b1;
          i_nxt = '0;
        end
      end
      nbs_pkg::S_LAT_I: begin
        cand_nxt = rd_data_r;
        jd_nxt   = '0;
      end
      nbs_pkg::S_CMP: begin
        if (cmp_done) begin
          kept_nxt = kept_fin;
          i_nxt    = last_i ? '0 : i_r + IDX_W'(1);
        end else begin
          jd_nxt = jd_r + IDX_W'(1);
        end
      end
      nbs_pkg::S_EMIT_CHK: begin
        if (mark_rd_r || out_free) begin
          i_nxt = i_r + IDX_W'(1);
        end
        if (!mark_rd_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, nbs_pkg::OUT_INDEX_W'(i_r),
                           CW'(rd_data_r[3*COORD_BITS +: COORD_BITS]),
                           CW'(rd_data_r[2*COORD_BITS +: COORD_BITS]),
                           CW'(rd_data_r[1*COORD_BITS +: COORD_BITS]),
                           CW'(rd_data_r[0*COORD_BITS +: COORD_BITS])};
          out_user_nxt  = '0;
          out_user_nxt[nbs_pkg::USER_OVF] = dropped_r;
          out_last_nxt  = emit_last;
          emitted_nxt   = emitted_r + RW'(1);
        end
        if (state_nxt == nbs_pkg::S_LOAD) begin
          box_count_nxt = '0;
          dropped_nxt   = 1'b0;
          kept_nxt      = '0;
          emitted_nxt   = '0;
          i_nxt         = '0;
        end
      end
      nbs_pkg::S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_user_nxt  = '0;
          out_user_nxt[nbs_pkg::USER_EMPTY] = 1'b1;
          out_user_nxt[nbs_pkg::USER_OVF]   = dropped_r;
          out_last_nxt  = 1'b1;
          box_count_nxt = '0;
          dropped_nxt   = 1'b0;
          kept_nxt      = '0;
          emitted_nxt   = '0;
          i_nxt         = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nbs_pkg::S_LOAD;
      box_count_r <= '0;
      dropped_r   <= 1'b0;
      i_r         <= '0;
      jd_r        <= '0;
      kept_r      <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      box_count_r <= box_count_nxt;
      dropped_r   <= dropped_nxt;
      i_r         <= i_nxt;
      jd_r        <= jd_nxt;
      kept_r      <= kept_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`include "assert_macros.svh"

  // An empty-set word carries no box and always closes the set.
  `ASSERT_IMP(a_empty_word, out_valid_r && out_user_r[nbs_pkg::USER_EMPTY],
              out_data_r == '0 && out_last_r, "empty-set word with payload or without tlast")

  // A set closed by tlast stops the input until its final word enters the output register.
  `ASSERT_NXT(a_last_stops_input, in_acc && in_tlast, !in_tready,
              "input still ready after the final box of a set")

  // The scan only inspects boxes while results are still owed.
  `ASSERT_IMP(a_emit_owed, state_r == nbs_pkg::S_EMIT_CHK,
              emitted_r < kept_r && kept_r <= RW'(nbs_pkg::RESULT_LIMIT),
              "emission scan running with no result owed")

  // The fill count never passes the store depth.
  `ASSERT_IMP(a_count_bound, in_acc, box_count_r <= CNT_W'(MAX_BOXES),
              "box count beyond store depth")

endmodule

### tb/nested_box_suppression_unit_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the nested box suppression unit. Sets of boxes are
// streamed in; a behavioral predictor keeps its own copy of the box store and
// works out, at the word that closes each set, which boxes survive the
// containment filter. Every word that leaves the block is compared field by
// field with the oldest prediction. Both stream sides idle at random, and one
// long receiver hold-off lets the block fill up and stall its input.
module nested_box_suppression_unit_test;

  localparam int unsigned STORE_DEPTH  = 64;
  localparam int unsigned PLAN_ROWS    = 20;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [nbs_pkg::IN_COORD_W-1:0] x, y, w, h;
  } box_t;

  // One word of the result stream, unpacked into its fields.
  typedef struct packed {
    logic [nbs_pkg::IN_COORD_W-1:0]  x, y, w, h;
    logic [nbs_pkg::OUT_INDEX_W-1:0] index;
    logic                            last;
    logic                            empty;
    logic                            ovf;
  } box_word_t;

  // One row of the directed table. Where typed is set, want holds the single
  // word the set must produce; otherwise the predictor supplies the words.
  typedef struct packed {
    box_t      box;
    logic      last;
    logic      typed;
    box_word_t want;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic [nbs_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tlast = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [nbs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [nbs_pkg::OUT_USER_W-1:0] out_tuser;
  logic                           out_tlast;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;

  logic quiet = 1'b0;     // no idling on either side while set
  logic hold_off = 1'b0;  // long receiver stall in progress

  int unsigned err_count = 0;
  int unsigned boxes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_pause = 0;

  // Predictor state: its own copy of the box store.
  box_t        held_boxes [STORE_DEPTH];
  int unsigned held_count = 0;
  logic        held_dropped = 1'b0;

  box_word_t   set_words [$];       // words predicted for the set just closed
  box_word_t   expected_words [$];  // words still owed by the block
  box_t        set_boxes [$];       // boxes of the set being generated

  plan_row_t   plan [PLAN_ROWS];

  always #10 clk = ~clk;

  nested_box_suppression_unit #(
    .MAX_BOXES (STORE_DEPTH),
    .COORD_BITS(nbs_pkg::IN_COORD_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // Box r lies within box f; the right and bottom edges are summed in 32 bits
  // so that they never wrap.
  function automatic bit lies_within(input box_t r, input box_t f);
    int unsigned r_right, r_bottom, f_right, f_bottom;
    r_right  = 32'(r.x) + 32'(r.w);
    r_bottom = 32'(r.y) + 32'(r.h);
    f_right  = 32'(f.x) + 32'(f.w);
    f_bottom = 32'(f.y) + 32'(f.h);
    return r.x >= f.x && r.y >= f.y && r_right <= f_right && r_bottom <= f_bottom;
  endfunction

  // Loads one box into the predictor. On the closing box of a set, fills
  // set_words with the predicted result words in load order and clears the store.
  function automatic void predict_survivors(input box_t b, input logic last_box);
    logic        covered [STORE_DEPTH];
    int unsigned n_kept;
    int unsigned n_sent;
    box_word_t   w;
    set_words.delete();
    if (held_count < STORE_DEPTH) begin
      held_boxes[held_count] = b;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last_box) return;

    n_kept = 0;
    for (int i = 0; i < held_count; i++) begin
      covered[i] = 1'b0;
      for (int j = 0; j < held_count; j++) begin
        if (j != i && lies_within(held_boxes[i], held_boxes[j])) covered[i] = 1'b1;
      end
      if (!covered[i]) n_kept++;
    end
    if (n_kept > nbs_pkg::RESULT_LIMIT) n_kept = nbs_pkg::RESULT_LIMIT;

    if (n_kept == 0) begin
      w = '0;
      w.last = 1'b1;
      w.empty = 1'b1;
      w.ovf = held_dropped;
      set_words = {set_words, w};
    end else begin
      n_sent = 0;
      for (int i = 0; i < held_count && n_sent < n_kept; i++) begin
        if (!covered[i]) begin
          w.x = held_boxes[i].x;
          w.y = held_boxes[i].y;
          w.w = held_boxes[i].w;
          w.h = held_boxes[i].h;
          w.index = i[nbs_pkg::OUT_INDEX_W-1:0];
          w.last = (n_sent + 1 == n_kept);
          w.empty = 1'b0;
          w.ovf = held_dropped;
          set_words = {set_words, w};
          n_sent++;
        end
      end
    end
    held_count = 0;
    held_dropped = 1'b0;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Random box for the current set. Much of it is derived from boxes already
  // in the set (copies, boxes inside them, boxes around them) so that the
  // containment filter actually removes things.
  function automatic box_t make_box(input int unsigned span);
    box_t        b, f;
    int unsigned r, f_right, f_bottom, top, need;
    r = $urandom_range(99);
    if (set_boxes.size() > 0 && r < 60) begin
      f = set_boxes[$urandom_range(set_boxes.size() - 1)];
      f_right = 32'(f.x) + 32'(f.w);
      f_bottom = 32'(f.y) + 32'(f.h);
      if (r < 15) return f;
      if (r < 45) begin
        // Nested inside f, edges allowed to touch.
        top = (f_right - 1 > 4095) ? 4095 : f_right - 1;
        b.x = 12'($urandom_range(top, f.x));
        top = (f_right - b.x > 4095) ? 4095 : f_right - b.x;
        b.w = 12'($urandom_range(top, 1));
        top = (f_bottom - 1 > 4095) ? 4095 : f_bottom - 1;
        b.y = 12'($urandom_range(top, f.y));
        top = (f_bottom - b.y > 4095) ? 4095 : f_bottom - b.y;
        b.h = 12'($urandom_range(top, 1));
        return b;
      end
      // Around f where the width allows, otherwise just somewhere near.
      b.x = 12'($urandom_range(f.x, 0));
      need = f_right - b.x;
      b.w = 12'((need > 4095) ? 4095
                : $urandom_range((need + 20 > 4095) ? 4095 : need + 20, need));
      b.y = 12'($urandom_range(f.y, 0));
      need = f_bottom - b.y;
      b.h = 12'((need > 4095) ? 4095
                : $urandom_range((need + 20 > 4095) ? 4095 : need + 20, need));
      return b;
    end
    if (r < 72) begin
      b.x = 12'($urandom_range(4095));
      b.y = 12'($urandom_range(4095));
      b.w = 12'($urandom_range(4095, 1));
      b.h = 12'($urandom_range(4095, 1));
    end else if (r < 78) begin
      b.x = $urandom_range(1) ? 12'd4095 : 12'd0;
      b.y = $urandom_range(1) ? 12'd4095 : 12'd0;
      b.w = $urandom_range(1) ? 12'd4095 : 12'd1;
      b.h = $urandom_range(1) ? 12'd4095 : 12'd1;
    end else begin
      b.x = 12'($urandom_range(span));
      b.y = 12'($urandom_range(span));
      b.w = 12'($urandom_range(span / 2 + 1, 1));
      b.h = 12'($urandom_range(span / 2 + 1, 1));
    end
    return b;
  endfunction

  // Offers one box word and waits for the block to take it. tvalid stays high
  // between back-to-back words and is only lowered for a gap.
  task automatic send_box(input box_t b, input logic last_box, input logic typed,
                          input box_word_t want);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b.h, b.w, b.y, b.x};
    in_tlast <= last_box;
    do @(posedge clk); while (!in_tready);
    predict_survivors(b, last_box);
    if (typed) begin
      expected_words = {expected_words, want};
    end else begin
      expected_words = {expected_words, set_words};
    end
    boxes_sent++;
  endtask

  function automatic void match(input string name, input int unsigned want,
                                input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  task automatic check_word();
    box_word_t want;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
      err_count++;
      return;
    end
    want = expected_words.pop_front();
    match("out_x", 32'(want.x), 32'(out_tdata[11:0]));
    match("out_y", 32'(want.y), 32'(out_tdata[23:12]));
    match("out_width", 32'(want.w), 32'(out_tdata[35:24]));
    match("out_height", 32'(want.h), 32'(out_tdata[47:36]));
    match("out_index", 32'(want.index), 32'(out_tdata[53:48]));
    match("out_last", 32'(want.last), 32'(out_tlast));
    match("empty_set", 32'(want.empty), 32'(out_tuser[nbs_pkg::USER_EMPTY]));
    match("overflow", 32'(want.ovf), 32'(out_tuser[nbs_pkg::USER_OVF]));
  endtask

  // Receiver: checks accepted words and stalls at random.
  always @(posedge clk) begin : receiver
    if (rst_n && out_tvalid && out_tready) check_word();
    if (rx_pause == 0 && $urandom_range(4) == 0) rx_pause = idle_len();
    if (rx_pause > 0) begin
      out_tready <= 1'b0;
      rx_pause--;
    end else begin
      out_tready <= !hold_off;
    end
  end

  // One long hold-off on the result side while boxes keep coming, so that
  // the block finishes a set, cannot emit it and closes its input.
  initial begin : backpressure
    wait (boxes_sent >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    box_t        b;
    int unsigned set_len;
    int unsigned set_no;
    int unsigned span;

    // Directed sets. Single-box sets at the corners and the duplicate pair
    // have obvious answers; the rest go through the predictor.
    plan = '{
      // Smallest box at the origin.
      '{'{12'd0, 12'd0, 12'd1, 12'd1}, 1'b1, 1'b1,
        '{12'd0, 12'd0, 12'd1, 12'd1, 6'd0, 1'b1, 1'b0, 1'b0}},
      // Largest box at the far corner.
      '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, 1'b1,
        '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 6'd0, 1'b1, 1'b0, 1'b0}},
      // Exact duplicates remove each other, leaving an empty set.
      '{'{12'd5, 12'd5, 12'd1, 12'd1}, 1'b0, 1'b0, '0},
      '{'{12'd5, 12'd5, 12'd1, 12'd1}, 1'b1, 1'b1,
        '{12'd0, 12'd0, 12'd0, 12'd0, 6'd0, 1'b1, 1'b1, 1'b0}},
      // Outer box loaded first, then inner.
      '{'{12'd0, 12'd0, 12'd100, 12'd100}, 1'b0, 1'b0, '0},
      '{'{12'd10, 12'd10, 12'd20, 12'd20}, 1'b1, 1'b0, '0},
      // Inner box loaded first, so the survivor has index one.
      '{'{12'd10, 12'd10, 12'd20, 12'd20}, 1'b0, 1'b0, '0},
      '{'{12'd0, 12'd0, 12'd100, 12'd100}, 1'b1, 1'b0, '0},
      // Edge sums beyond 12 bits must not wrap.
      '{'{12'd4000, 12'd4000, 12'd4095, 12'd4095}, 1'b0, 1'b0, '0},
      '{'{12'd4095, 12'd4095, 12'd4000, 12'd4000}, 1'b1, 1'b0, '0},
      // Duplicates, a box sharing their right and bottom edges, a thin strip
      // and two boxes that only touch.
      '{'{12'd100, 12'd100, 12'd50, 12'd50}, 1'b0, 1'b0, '0},
      '{'{12'd100, 12'd100, 12'd50, 12'd50}, 1'b0, 1'b0, '0},
      '{'{12'd120, 12'd120, 12'd30, 12'd30}, 1'b0, 1'b0, '0},
      '{'{12'd0, 12'd0, 12'd1, 12'd4095}, 1'b0, 1'b0, '0},
      '{'{12'd2000, 12'd50, 12'd10, 12'd10}, 1'b0, 1'b0, '0},
      '{'{12'd2000, 12'd60, 12'd10, 12'd10}, 1'b1, 1'b0, '0},
      // Overlap shifted by one column: neither is inside the other.
      '{'{12'd1, 12'd2, 12'd3, 12'd4}, 1'b0, 1'b0, '0},
      '{'{12'd0, 12'd2, 12'd3, 12'd4}, 1'b1, 1'b0, '0},
      // Alternating bit patterns.
      '{'{12'hAAA, 12'h555, 12'hAAA, 12'h555}, 1'b0, 1'b0, '0},
      '{'{12'h555, 12'hAAA, 12'h555, 12'hAAA}, 1'b1, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) send_box(plan[k].box, plan[k].last, plan[k].typed, plan[k].want);

    // Random sets, mostly small. Three large ones fill the store: one exactly
    // full, and two that drop boxes and close on a dropped box.
    set_no = 0;
    while (boxes_sent < PLAN_ROWS + RANDOM_ITEMS) begin
      case (set_no)
        4:       set_len = STORE_DEPTH;
        12:      set_len = STORE_DEPTH + 6;
        20:      set_len = STORE_DEPTH + 1;
        default: set_len = ($urandom_range(9) < 8) ? $urandom_range(8, 1)
                                                    : $urandom_range(24, 9);
      endcase
      span = $urandom_range(1) ? 200 : 4000;
      quiet <= ($urandom_range(5) == 0);
      set_boxes.delete();
      for (int k = 0; k < set_len; k++) begin
        b = make_box(span);
        set_boxes = {set_boxes, b};
        send_box(b, k == set_len - 1, 1'b0, '0);
      end
      set_no++;
    end
    in_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/nbs_pkg.sv
rtl/nbs_contain.sv
rtl/nested_box_suppression_unit.sv
tb/nested_box_suppression_unit_test.sv
